// File: rtl/symmetric_matrix_packer_core_defines.svh
// assertion macros for the symmetric matrix packer
// used by rtl/symmetric_matrix_packer_core.sv; no other dependencies
`ifndef SYMMETRIC_MATRIX_PACKER_CORE_DEFINES_SVH
`define SYMMETRIC_MATRIX_PACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("smp assertion failed");
`define SMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smp assertion failed");
`else
`define SMP_ASSERT(lbl, clk, rst_n, prop)
`define SMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/smp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the symmetric matrix packer
// no dependencies
package smp_pkg;

  localparam int MAX_ORDER_DEF = 8;
  localparam int ELEM_W        = 32;
  localparam int ORDER_W       = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 4'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_CHK_DONE,
    ST_FAIL,
    ST_EMIT_RD,
    ST_EMIT_LD
  } smp_state_e;

endpackage

// File: rtl/symmetric_matrix_packer_core.sv
`timescale 1ns / 1ps
// Symmetric matrix packer. Coefficients of an n x n matrix (n from cfg, clamped to
// 1..MAX_ORDER) enter one beat per cycle in row-major order. After the last one the
// block walks the strict lower triangle, one (r,c)/(c,r) pair per cycle from two
// mirrored rams (no walk for n = 1), then checks the last pair. A symmetric matrix is
// then sent as n(n+1)/2 beats of its lower triangle, row by row, each a ram read
// followed by an output register load; otherwise one beat with is_symmetric low.
// The single registered read port of each ram paces both the walk and the emission.
// Depends on smp_pkg, smp_ram and symmetric_matrix_packer_core_defines.svh.
`include "symmetric_matrix_packer_core_defines.svh"

module symmetric_matrix_packer_core #(
  parameter int MAX_ORDER = smp_pkg::MAX_ORDER_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [smp_pkg::ORDER_W-1:0]       cfg_wdata_i,    // matrix_order
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic signed [smp_pkg::ELEM_W-1:0] s_axis_tdata_i, // element_value
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic signed [smp_pkg::ELEM_W-1:0] m_axis_tdata_o, // packed_value
  output logic                              m_axis_tuser_o, // is_symmetric
  output logic                              m_axis_tlast_o  // last_of_run
);

  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = $clog2(MAX_ORDER + 1);
  localparam int CW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int PW    = CW + NW + 1;
  localparam int SQW   = 2 * NW;
  localparam int EW    = smp_pkg::ELEM_W;
  localparam int OW    = smp_pkg::ORDER_W;

  smp_pkg::smp_state_e state_q, state_d;

  logic [OW-1:0] order_q;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] row_q, row_d, col_q, col_d;
  logic          mism_q, mism_d;
  logic          chk_vld_q, chk_vld_d;

  logic          out_valid_q;
  logic [EW-1:0] out_data_q, out_data_d;
  logic          out_sym_q, out_sym_d;
  logic          out_last_q, out_last_d;
  logic          load_out;

  logic [NW-1:0]  n_eff, n_m1_full;
  logic [CW-1:0]  n_m1, row_m1;
  logic [SQW-1:0] total;
  logic [PW-1:0]  addr_a_full, addr_b_full;
  logic [EW-1:0]  rdata_a, rdata_b;
  logic           wr_en, out_free, pair_neq;

  // effective order: zero reads as one, large values saturate
  always_comb begin
    if (order_q == '0) begin
      n_eff = NW'(1);
    end else if (order_q > OW'(MAX_ORDER)) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = order_q[NW-1:0];
    end
  end

  assign n_m1_full = n_eff - NW'(1);
  assign n_m1      = n_m1_full[CW-1:0];
  assign row_m1    = row_q - CW'(1);
  assign total     = SQW'(n_eff) * SQW'(n_eff);

  assign addr_a_full = PW'(row_q) * PW'(n_eff) + PW'(col_q);
  assign addr_b_full = PW'(col_q) * PW'(n_eff) + PW'(row_q);

  // two mirrored copies so both halves of a pair are read in one cycle
  smp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q),
    .wr_data_i (s_axis_tdata_i),
    .rd_addr_i (addr_a_full[AW-1:0]),
    .rd_data_o (rdata_a)
  );

  smp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (cnt_q),
    .wr_data_i (s_axis_tdata_i),
    .rd_addr_i (addr_b_full[AW-1:0]),
    .rd_data_o (rdata_b)
  );

  assign pair_neq = (rdata_a != rdata_b);
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    row_d           = row_q;
    col_d           = col_q;
    mism_d          = mism_q;
    chk_vld_d       = 1'b0;
    wr_en           = 1'b0;
    load_out        = 1'b0;
    out_data_d      = rdata_a;
    out_sym_d       = 1'b1;
    out_last_d      = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      smp_pkg::ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          wr_en = 1'b1;
          if (SQW'(cnt_q) + SQW'(1) == total) begin
            cnt_d  = '0;
            col_d  = '0;
            mism_d = 1'b0;
            if (n_eff == NW'(1)) begin
              row_d   = '0;
              state_d = smp_pkg::ST_EMIT_RD;
            end else begin
              row_d   = CW'(1);
              state_d = smp_pkg::ST_CHECK;
            end
          end else begin
            cnt_d = cnt_q + AW'(1);
          end
        end
      end
      smp_pkg::ST_CHECK: begin
        chk_vld_d = 1'b1;
        mism_d    = mism_q | (chk_vld_q & pair_neq);
        if (col_q == row_m1) begin
          col_d = '0;
          if (row_q == n_m1) begin
            state_d = smp_pkg::ST_CHK_DONE;
          end else begin
            row_d = row_q + CW'(1);
          end
        end else begin
          col_d = col_q + CW'(1);
        end
      end
      smp_pkg::ST_CHK_DONE: begin
        row_d = '0;
        col_d = '0;
        if (mism_q || (chk_vld_q && pair_neq)) begin
          state_d = smp_pkg::ST_FAIL;
        end else begin
          state_d = smp_pkg::ST_EMIT_RD;
        end
      end
      smp_pkg::ST_FAIL: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_data_d = '0;
          out_sym_d  = 1'b0;
          out_last_d = 1'b1;
          state_d    = smp_pkg::ST_LOAD;
        end
      end
      smp_pkg::ST_EMIT_RD: begin
        // read is issued now; the output register is empty when data lands
        if (out_free) begin
          state_d = smp_pkg::ST_EMIT_LD;
        end
      end
      smp_pkg::ST_EMIT_LD: begin
        load_out   = 1'b1;
        out_last_d = (row_q == n_m1) && (col_q == row_q);
        if (col_q == row_q) begin
          col_d = '0;
          row_d = row_q + CW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
        state_d = out_last_d ? smp_pkg::ST_LOAD : smp_pkg::ST_EMIT_RD;
      end
      default: begin
        state_d = smp_pkg::ST_LOAD;
      end
    endcase

    // a new order restarts the load
    if (cfg_we_i) begin
      cnt_d   = '0;
      state_d = smp_pkg::ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= smp_pkg::ST_LOAD;
      order_q     <= smp_pkg::ORDER_RESET;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      mism_q      <= 1'b0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      col_q     <= col_d;
      mism_q    <= mism_d;
      chk_vld_q <= chk_vld_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= out_data_d;
      out_sym_q  <= out_sym_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_sym_q;
  assign m_axis_tlast_o  = out_last_q;

  `SMP_ASSERT(a_emit_slot_free, clk_i, rst_ni, (state_q != smp_pkg::ST_EMIT_LD) || !out_valid_q)
  `SMP_ASSERT(a_load_cnt_range, clk_i, rst_ni, (state_q != smp_pkg::ST_LOAD) || (SQW'(cnt_q) < total))
  `SMP_ASSERT(a_check_lower, clk_i, rst_ni, (state_q != smp_pkg::ST_CHECK) || (col_q < row_q))
  `SMP_ASSERT_NEXT(a_emit_follows_rd, clk_i, rst_ni, (state_q == smp_pkg::ST_EMIT_RD) && out_free && !cfg_we_i, state_q == smp_pkg::ST_EMIT_LD)

endmodule

// File: rtl/smp_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
// no dependencies
module smp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for symmetric_matrix_packer_core: streams square matrices of many orders,
// predicts the packed lower triangle or the single asymmetry beat, and checks each output beat
// depends on smp_pkg and the rtl of the core
module tb_top;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int DIRECTED_CNT  = 25;
  localparam int TARGET_ITEMS  = 500;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 17;

  typedef struct packed {
    logic signed [smp_pkg::ELEM_W-1:0] coeff;
    logic                              sym_flag;
    logic                              last_flag;
  } tri_beat_t;

  logic                              clk_i           = 1'b0;
  logic                              rst_ni          = 1'b0;
  logic                              cfg_we_i        = 1'b0;
  logic [smp_pkg::ORDER_W-1:0]       cfg_wdata_i     = '0;
  logic                              s_axis_tvalid_i = 1'b0;
  logic                              s_axis_tready_o;
  logic signed [smp_pkg::ELEM_W-1:0] s_axis_tdata_i  = '0;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic signed [smp_pkg::ELEM_W-1:0] m_axis_tdata_o;
  logic                              m_axis_tuser_o;
  logic                              m_axis_tlast_o;

  // stimulus and expected beats
  logic [smp_pkg::ELEM_W-1:0] elem_pending_q[$];
  tri_beat_t                  tri_expect_q[$];
  tri_beat_t                  want_beat;

  // mirror of the block state
  logic [smp_pkg::ELEM_W-1:0]  coeff_store [64];
  logic [6:0]                  loaded_cnt;
  logic [smp_pkg::ORDER_W-1:0] order_reg;

  int unsigned mismatch_cnt = 0;
  int unsigned items_queued = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned hold_left    = 0;
  bit          hold_req     = 1'b0;
  bit          steady_flow  = 1'b0;
  bit          elem_taken   = 1'b0;

  symmetric_matrix_packer_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL symmetric_matrix_packer_core");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
    mismatch_cnt++;
  endtask

  function automatic int unsigned clamp_order(input logic [smp_pkg::ORDER_W-1:0] v);
    if (v == 0) return 1;
    if (v > smp_pkg::MAX_ORDER_DEF) return smp_pkg::MAX_ORDER_DEF;
    return v;
  endfunction

  // loads one coefficient; a completed matrix yields its triangle or one asymmetry beat
  task automatic absorb_element(input logic [smp_pkg::ELEM_W-1:0] v);
    int unsigned n, total, r, c;
    bit          mirror_ok;
    tri_beat_t   b;
    n     = clamp_order(order_reg);
    total = n * n;
    if (loaded_cnt >= total) loaded_cnt = '0;
    coeff_store[loaded_cnt[5:0]] = v;
    loaded_cnt = loaded_cnt + 7'd1;
    if (loaded_cnt < total) return;
    loaded_cnt = '0;
    mirror_ok = 1'b1;
    for (r = 0; r < n; r++)
      for (c = 0; c < r; c++)
        if (coeff_store[r*n+c] != coeff_store[c*n+r]) mirror_ok = 1'b0;
    if (!mirror_ok) begin
      b.coeff     = '0;
      b.sym_flag  = 1'b0;
      b.last_flag = 1'b1;
      tri_expect_q.push_back(b);
    end else begin
      for (r = 0; r < n; r++)
        for (c = 0; c <= r; c++) begin
          b.coeff     = coeff_store[r*n+c];
          b.sym_flag  = 1'b1;
          b.last_flag = (r == n - 1) && (c == r);
          tri_expect_q.push_back(b);
        end
    end
  endtask

  // sender: sample acceptance at the rising edge, drive at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      absorb_element(s_axis_tdata_i);
      elem_taken = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || elem_taken)) begin
      elem_taken = 1'b0;
      if (elem_pending_q.size() != 0 && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= elem_pending_q.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (tri_expect_q.size() == 0) begin
        report_mismatch("output beat with nothing expected", m_axis_tdata_o, '0);
      end else begin
        want_beat = tri_expect_q.pop_front();
        if (m_axis_tdata_o !== want_beat.coeff)
          report_mismatch("packed_value", m_axis_tdata_o, want_beat.coeff);
        if (m_axis_tuser_o !== want_beat.sym_flag)
          report_mismatch("is_symmetric", 32'(m_axis_tuser_o), 32'(want_beat.sym_flag));
        if (m_axis_tlast_o !== want_beat.last_flag)
          report_mismatch("last_of_run", 32'(m_axis_tlast_o), 32'(want_beat.last_flag));
      end
    end
  end

  function automatic logic [smp_pkg::ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic push_elem(input logic [smp_pkg::ELEM_W-1:0] v);
    elem_pending_q.push_back(v);
    items_queued++;
  endtask

  // symmetric content, or one off-diagonal entry spoiled
  task automatic queue_matrix(input int unsigned n, input bit want_sym);
    logic [smp_pkg::ELEM_W-1:0] m [smp_pkg::MAX_ORDER_DEF][smp_pkg::MAX_ORDER_DEF];
    int unsigned                r, c;
    for (r = 0; r < n; r++)
      for (c = 0; c <= r; c++) begin
        m[r][c] = rand_elem();
        m[c][r] = m[r][c];
      end
    if (!want_sym && n > 1) begin
      r = $urandom_range(1, n - 1);
      c = $urandom_range(0, r - 1);
      if ($urandom_range(0, 1) == 0)
        m[r][c] = m[r][c] ^ (32'd1 << $urandom_range(0, 31));
      else
        m[c][r] = ~m[r][c];
    end
    for (r = 0; r < n; r++)
      for (c = 0; c < n; c++)
        push_elem(m[r][c]);
  endtask

  task automatic wait_drained();
    while (elem_pending_q.size() != 0 || s_axis_tvalid_i || tri_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // order writes only with the block idle; a write also drops a partial matrix
  task automatic set_order(input logic [smp_pkg::ORDER_W-1:0] v);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    order_reg  = v;
    loaded_cnt = '0;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase, n, nmat;
    logic [smp_pkg::ORDER_W-1:0] ord;
    order_reg  = smp_pkg::ORDER_RESET;
    loaded_cnt = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // order 1 from reset: extremes of the coefficient
    push_elem(32'h8000_0000);
    push_elem(32'h7fff_ffff);
    push_elem(32'h0000_0000);
    push_elem(32'hffff_ffff);
    // zero order acts as order 1
    set_order(4'd0);
    push_elem(32'h0001_0000);
    // order 2: symmetric, then off by one bit
    set_order(4'd2);
    push_elem(32'h8000_0000);
    push_elem(32'h7fff_ffff);
    push_elem(32'h7fff_ffff);
    push_elem(32'hffff_ffff);
    push_elem(32'h0000_0000);
    push_elem(32'h7fff_ffff);
    push_elem(32'h7fff_fffe);
    push_elem(32'h0000_0000);
    // partial load, then a write that restarts it
    push_elem(32'h0000_0001);
    push_elem(32'h0000_0002);
    push_elem(32'h0000_0003);
    set_order(4'd3);
    queue_matrix(3, 1'b1);

    phase = 0;
    while (items_queued < DIRECTED_CNT + TARGET_ITEMS) begin
      if (phase == 0)
        ord = 4'd8;
      else if (phase == 1)
        ord = 4'd15;
      else if ($urandom_range(0, 3) == 0)
        ord = 4'($urandom_range(9, 15));
      else
        ord = 4'($urandom_range(0, 8));
      steady_flow = (phase >= 2 && phase <= 4);
      set_order(ord);
      n = clamp_order(ord);
      // sender keeps pushing full-size matrices into a stalled receiver
      if (phase == 0) hold_req = 1'b1;
      nmat = (phase == 0) ? 4 : $urandom_range(1, 4);
      repeat (nmat) queue_matrix(n, $urandom_range(0, 99) < 70);
      if (n > 1 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, n * n - 1)) push_elem(rand_elem());
      phase++;
    end
    steady_flow = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tri_expect_q.size() != 0)
      report_mismatch("beats never delivered", tri_expect_q.size(), '0);
    if (mismatch_cnt == 0)
      $display("PASS symmetric_matrix_packer_core");
    else
      $display("FAIL symmetric_matrix_packer_core");
    $finish;
  end

endmodule
